### sv/vwvt_pkg.sv
// ----------------------------------------------------------------------------
// vwvt_pkg: shared types and constants
// Widths, register indexes and the flash brightness table for the transform.
// ----------------------------------------------------------------------------
package vwvt_pkg;

    localparam int CoordW   = 12;
    localparam int ViewW    = 16;
    localparam int SizeW    = 13;
    localparam int OrientW  = 14;
    localparam int QuotW    = 28;
    localparam int Span     = 36000;

    typedef enum logic [2:0] {
        REG_WIN_LEFT   = 3'd0,
        REG_WIN_BOTTOM = 3'd1,
        REG_WIN_RIGHT  = 3'd2,
        REG_WIN_TOP    = 3'd3,
        REG_ROTATE     = 3'd4,
        REG_MIRROR_X   = 3'd5,
        REG_MIRROR_Y   = 3'd6,
        REG_TWINKLE    = 3'd7
    } reg_idx_t;

    // Flash brightness 127*(sin+49152)/65536 for each phase.
    function automatic logic [6:0] flash_bright(input logic [4:0] ph);
        logic [6:0] r;
        begin
            case (ph)
                5'd0:  r = 7'd95;  5'd1:  r = 7'd101; 5'd2:  r = 7'd107;
                5'd3:  r = 7'd112; 5'd4:  r = 7'd117; 5'd5:  r = 7'd121;
                5'd6:  r = 7'd124; 5'd7:  r = 7'd126; 5'd8:  r = 7'd127;
                5'd9:  r = 7'd126; 5'd10: r = 7'd124; 5'd11: r = 7'd121;
                5'd12: r = 7'd117; 5'd13: r = 7'd112; 5'd14: r = 7'd107;
                5'd15: r = 7'd101; 5'd16: r = 7'd95;  5'd17: r = 7'd89;
                5'd18: r = 7'd83;  5'd19: r = 7'd77;  5'd20: r = 7'd72;
                5'd21: r = 7'd68;  5'd22: r = 7'd65;  5'd23: r = 7'd64;
                5'd24: r = 7'd63;  5'd25: r = 7'd64;  5'd26: r = 7'd65;
                5'd27: r = 7'd68;  5'd28: r = 7'd72;  5'd29: r = 7'd77;
                5'd30: r = 7'd83;  5'd31: r = 7'd89;
                default: r = 7'd95;
            endcase
            return r;
        end
    endfunction

endpackage

### sv/vwvt_lane.sv
// ----------------------------------------------------------------------------
// vwvt_lane: one coordinate scaling lane
// Computes sat16((v - size/2)*36000/size) with a pipelined restoring divider.
// Stage 0, the divider stages and an output register; one item per cycle.
// ----------------------------------------------------------------------------
module vwvt_lane
    import vwvt_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic signed [OrientW-1:0] coord,
    input  logic        [SizeW-1:0]   size,
    output logic                      out_valid,
    output logic signed [ViewW-1:0]   view
);

    localparam int NumW = 31;
    localparam int Steps = QuotW;

    // Stage 0: offset and multiply, keep magnitude and sign.
    logic                  s0_valid_reg;
    logic [NumW-1:0]       s0_mag_reg;
    logic                  s0_neg_reg;
    logic [SizeW-1:0]      s0_size_reg;

    logic signed [OrientW:0]  diff;
    logic signed [NumW:0]     prod;
    logic [NumW-1:0]          mag_next;

    always_comb
    begin
        diff = OrientW'(coord) - $signed({2'b00, size[SizeW-1:1]});
        prod = diff * $signed(17'd36000);
        mag_next = prod[NumW] ? NumW'(-prod) : prod[NumW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else
            s0_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        s0_mag_reg  <= mag_next;
        s0_neg_reg  <= prod[NumW];
        s0_size_reg <= size;
    end

    // Divider stages: one quotient bit per stage, MSB first.
    logic                  dv_valid_reg [Steps+1];
    logic [NumW-1:0]       dv_rem_reg   [Steps+1];
    logic [NumW-1:0]       dv_num_reg   [Steps+1];
    logic [QuotW-1:0]      dv_quot_reg  [Steps+1];
    logic                  dv_neg_reg   [Steps+1];
    logic [SizeW-1:0]      dv_size_reg  [Steps+1];

    // The quotient always fits in QuotW bits, so the numerator bits above
    // QuotW are smaller than the size and seed the partial remainder.
    always_comb
    begin
        dv_valid_reg[0] = s0_valid_reg;
        dv_rem_reg[0]   = NumW'(s0_mag_reg[NumW-1:QuotW]);
        dv_num_reg[0]   = {s0_mag_reg[QuotW-1:0], {(NumW-QuotW){1'b0}}};
        dv_quot_reg[0]  = '0;
        dv_neg_reg[0]   = s0_neg_reg;
        dv_size_reg[0]  = s0_size_reg;
    end

    genvar g;
    generate
        for (g = 0; g < Steps; g++)
        begin : g_div
            logic [NumW-1:0] trial;
            logic [NumW:0]   sub;
            always_comb
            begin
                trial = {dv_rem_reg[g][NumW-2:0], dv_num_reg[g][NumW-1]};
                sub = {1'b0, trial} - {{(NumW+1-SizeW){1'b0}}, dv_size_reg[g]};
            end
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    dv_valid_reg[g+1] <= 1'b0;
                else
                    dv_valid_reg[g+1] <= dv_valid_reg[g];
            end
            always_ff @(posedge clk)
            begin
                dv_rem_reg[g+1]  <= sub[NumW] ? trial : sub[NumW-1:0];
                dv_num_reg[g+1]  <= {dv_num_reg[g][NumW-2:0], 1'b0};
                dv_quot_reg[g+1] <= {dv_quot_reg[g][QuotW-2:0], ~sub[NumW]};
                dv_neg_reg[g+1]  <= dv_neg_reg[g];
                dv_size_reg[g+1] <= dv_size_reg[g];
            end
        end
    endgenerate

    // Final stage: apply sign and saturate.
    logic                 out_valid_reg;
    logic signed [ViewW-1:0] view_reg;
    logic signed [ViewW-1:0] view_next;
    logic [QuotW-1:0]     q;

    always_comb
    begin
        q = dv_quot_reg[Steps];
        if (dv_neg_reg[Steps])
            view_next = (q > QuotW'(32768)) ? 16'sh8000 : ViewW'(-q);
        else
            view_next = (q > QuotW'(32767)) ? 16'sh7fff : ViewW'(q);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= dv_valid_reg[Steps];
    end

    always_ff @(posedge clk)
    begin
        view_reg <= view_next;
    end

    assign out_valid = out_valid_reg;
    assign view      = view_reg;

endmodule

### sv/vwvt_front.sv
// ----------------------------------------------------------------------------
// vwvt_front: orientation and brightness stage
// Applies rotate and mirrors, measures window sizes, picks the brightness.
// ----------------------------------------------------------------------------
module vwvt_front
    import vwvt_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic signed [CoordW-1:0]  x0_in,
    input  logic signed [CoordW-1:0]  y0_in,
    input  logic signed [CoordW-1:0]  x1_in,
    input  logic signed [CoordW-1:0]  y1_in,
    input  logic        [3:0]         col,
    input  logic        [4:0]         phase,
    input  logic signed [CoordW-1:0]  wl,
    input  logic signed [CoordW-1:0]  wb,
    input  logic signed [CoordW-1:0]  wr,
    input  logic signed [CoordW-1:0]  wt,
    input  logic                      rot,
    input  logic                      mx,
    input  logic                      my,
    input  logic        [7:0]         twinkle,
    output logic                      out_valid,
    output logic signed [OrientW-1:0] ox0,
    output logic signed [OrientW-1:0] oy0,
    output logic signed [OrientW-1:0] ox1,
    output logic signed [OrientW-1:0] oy1,
    output logic        [SizeW-1:0]   sx,
    output logic        [SizeW-1:0]   sy,
    output logic        [6:0]         bright
);

    logic signed [OrientW-1:0] xsum, ysum;
    logic signed [OrientW-1:0] a0, b0, a1, b1, c0, c1, d0, d1;
    logic signed [SizeW:0]     dx, dy;
    logic [SizeW-1:0]          sx_next, sy_next;
    logic [6:0]                bright_next;

    always_comb
    begin
        xsum = OrientW'(wr) + OrientW'(wl);
        ysum = OrientW'(wt) + OrientW'(wb);
        // Rotation swaps axes then mirrors the new x.
        a0 = rot ? xsum - OrientW'(y0_in) : OrientW'(x0_in);
        a1 = rot ? xsum - OrientW'(y1_in) : OrientW'(x1_in);
        b0 = rot ? OrientW'(x0_in) : OrientW'(y0_in);
        b1 = rot ? OrientW'(x1_in) : OrientW'(y1_in);
        if ({4'd0, col} <= twinkle || a0 != a1 || b0 != b1)
            bright_next = {col, 3'b111};
        else
            bright_next = flash_bright(phase);
        c0 = mx ? xsum - a0 : a0;
        c1 = mx ? xsum - a1 : a1;
        d0 = my ? ysum - b0 : b0;
        d1 = my ? ysum - b1 : b1;
        dx = (SizeW+1)'(wr) - (SizeW+1)'(wl);
        dy = (SizeW+1)'(wt) - (SizeW+1)'(wb);
        sx_next = dx[SizeW] ? SizeW'(-dx) : dx[SizeW-1:0];
        sy_next = dy[SizeW] ? SizeW'(-dy) : dy[SizeW-1:0];
        if (sx_next == '0)
            sx_next = SizeW'(1);
        if (sy_next == '0)
            sy_next = SizeW'(1);
    end

    logic out_valid_reg;
    logic signed [OrientW-1:0] ox0_reg, oy0_reg, ox1_reg, oy1_reg;
    logic [SizeW-1:0] sx_reg, sy_reg;
    logic [6:0] bright_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        ox0_reg    <= c0;
        ox1_reg    <= c1;
        oy0_reg    <= d0;
        oy1_reg    <= d1;
        sx_reg     <= sx_next;
        sy_reg     <= sy_next;
        bright_reg <= bright_next;
    end

    assign out_valid = out_valid_reg;
    assign ox0 = ox0_reg;
    assign oy0 = oy0_reg;
    assign ox1 = ox1_reg;
    assign oy1 = oy1_reg;
    assign sx = sx_reg;
    assign sy = sy_reg;
    assign bright = bright_reg;

endmodule

### sv/vector_window_viewport_transform.sv
// ----------------------------------------------------------------------------
// vector_window_viewport_transform: window to viewport mapping of one vector
// Orients, scales and saturates both endpoints and picks the brightness.
// ----------------------------------------------------------------------------
// One item is taken per cycle whenever start is high (busy is always low).
// Its result appears with done high after the front stage register, then
// in each of the four coordinate lanes the multiply stage, the 28-stage
// pipelined divider and the output register. The receiver cannot
// stall, so results must be taken in the cycle they appear.
module vector_window_viewport_transform
    import vwvt_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [11:0]        start_x,
    input  logic signed [11:0]        start_y,
    input  logic signed [11:0]        end_x,
    input  logic signed [11:0]        end_y,
    input  logic        [3:0]         colour,
    input  logic        [4:0]         frame_phase,
    input  logic                      cfg_we,
    input  logic        [2:0]         cfg_index,
    input  logic        [11:0]        cfg_data,
    output logic                      done,
    output logic signed [15:0]        view_start_x,
    output logic signed [15:0]        view_start_y,
    output logic signed [15:0]        view_end_x,
    output logic signed [15:0]        view_end_y,
    output logic        [6:0]         brightness
);

    localparam int BrDepth = QuotW + 2;

    // Configuration registers.
    logic signed [CoordW-1:0] wl_reg, wb_reg, wr_reg, wt_reg;
    logic rot_reg, mx_reg, my_reg;
    logic [7:0] tw_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wl_reg <= '0; wb_reg <= '0; wr_reg <= '0; wt_reg <= '0;
            rot_reg <= 1'b0; mx_reg <= 1'b0; my_reg <= 1'b0;
            tw_reg <= 8'hff;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_WIN_LEFT:   wl_reg  <= cfg_data;
                REG_WIN_BOTTOM: wb_reg  <= cfg_data;
                REG_WIN_RIGHT:  wr_reg  <= cfg_data;
                REG_WIN_TOP:    wt_reg  <= cfg_data;
                REG_ROTATE:     rot_reg <= cfg_data[0];
                REG_MIRROR_X:   mx_reg  <= cfg_data[0];
                REG_MIRROR_Y:   my_reg  <= cfg_data[0];
                REG_TWINKLE:    tw_reg  <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // Orientation front end.
    logic f_valid;
    logic signed [OrientW-1:0] fx0, fy0, fx1, fy1;
    logic [SizeW-1:0] fsx, fsy;
    logic [6:0] fbright;

    vwvt_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(start),
        .x0_in(start_x), .y0_in(start_y), .x1_in(end_x), .y1_in(end_y),
        .col(colour), .phase(frame_phase),
        .wl(wl_reg), .wb(wb_reg), .wr(wr_reg), .wt(wt_reg),
        .rot(rot_reg), .mx(mx_reg), .my(my_reg), .twinkle(tw_reg),
        .out_valid(f_valid), .ox0(fx0), .oy0(fy0), .ox1(fx1), .oy1(fy1),
        .sx(fsx), .sy(fsy), .bright(fbright)
    );

    // Four scaling lanes.
    logic [3:0] lane_valid;
    vwvt_lane u_lane_sx (.clk(clk), .rst_n(rst_n), .in_valid(f_valid), .coord(fx0),
        .size(fsx), .out_valid(lane_valid[0]), .view(view_start_x));
    vwvt_lane u_lane_sy (.clk(clk), .rst_n(rst_n), .in_valid(f_valid), .coord(fy0),
        .size(fsy), .out_valid(lane_valid[1]), .view(view_start_y));
    vwvt_lane u_lane_ex (.clk(clk), .rst_n(rst_n), .in_valid(f_valid), .coord(fx1),
        .size(fsx), .out_valid(lane_valid[2]), .view(view_end_x));
    vwvt_lane u_lane_ey (.clk(clk), .rst_n(rst_n), .in_valid(f_valid), .coord(fy1),
        .size(fsy), .out_valid(lane_valid[3]), .view(view_end_y));

    // Brightness delay line aligned with the lanes.
    logic [6:0] br_reg [BrDepth];
    always_ff @(posedge clk)
    begin
        br_reg[0] <= fbright;
        for (int i = 1; i < BrDepth; i++)
            br_reg[i] <= br_reg[i-1];
    end

    // Merge: all lanes run in lockstep.
    assign done       = lane_valid[0];
    assign brightness = br_reg[BrDepth-1];

    a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        lane_valid == 4'b0000 || lane_valid == 4'b1111)
        else $error("scaling lanes out of step");
    a_front_follows: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> f_valid)
        else $error("front stage lost an item");
    a_bright_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> brightness >= 7'd7)
        else $error("brightness out of range");

endmodule

### tb/vector_window_viewport_transform_tb.sv
// ----------------------------------------------------------------------------
// vector_window_viewport_transform_tb: self-checking bench for the transform
// Drives vectors under a range of window and orientation settings, predicts
// each result in the bench and compares every field of every result.
// ----------------------------------------------------------------------------
module vector_window_viewport_transform_tb;
    import vwvt_pkg::*;

    typedef struct packed {
        logic signed [11:0] sx;
        logic signed [11:0] sy;
        logic signed [11:0] ex;
        logic signed [11:0] ey;
        logic [3:0]         col;
        logic [4:0]         ph;
    } vec_item_t;

    typedef struct packed {
        logic signed [15:0] vsx;
        logic signed [15:0] vsy;
        logic signed [15:0] vex;
        logic signed [15:0] vey;
        logic [6:0]         bri;
    } view_item_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [11:0] start_x, start_y, end_x, end_y;
    logic [3:0] colour;
    logic [4:0] frame_phase;
    logic cfg_we;
    logic [2:0] cfg_index;
    logic [11:0] cfg_data;
    logic done;
    logic signed [15:0] view_start_x, view_start_y, view_end_x, view_end_y;
    logic [6:0] brightness;

    // Bench copy of the configuration registers.
    int win_l, win_b, win_r, win_t;
    bit rot, mir_x, mir_y;
    int twinkle;

    vec_item_t  pending_vecs[$];
    view_item_t expected_views[$];
    vec_item_t  on_ports;
    int         gap_cnt;
    bit         no_idle;
    int         mismatches;

    // Sine of the flash phase, fp14.
    const int sine_tab[32] = '{
             0,   3196,   6269,   9102,  11585,  13622,  15136,  16069,
         16384,  16069,  15136,  13622,  11585,   9102,   6269,   3196,
             0,  -3196,  -6269,  -9102, -11585, -13622, -15136, -16069,
        -16384, -16069, -15136, -13622, -11585,  -9102,  -6269,  -3196};

    vector_window_viewport_transform dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
        .colour(colour), .frame_phase(frame_phase),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .view_start_x(view_start_x), .view_start_y(view_start_y),
        .view_end_x(view_end_x), .view_end_y(view_end_y), .brightness(brightness)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Scale one coordinate into the viewport and saturate to 16 bits.
    function automatic logic [15:0] scale_coord(longint v, longint size);
        longint r;
        begin
            r = ((v - size / 2) * Span) / size;
            if (r > 32767)
                r = 32767;
            if (r < -32768)
                r = -32768;
            return r[15:0];
        end
    endfunction

    // Expected viewport vector for one input vector under the current settings.
    function automatic view_item_t transform_vector(vec_item_t v);
        longint x0, y0, x1, y1, t, size_x, size_y;
        view_item_t r;
        begin
            x0 = v.sx;
            y0 = v.sy;
            x1 = v.ex;
            y1 = v.ey;
            size_x = (win_r > win_l) ? win_r - win_l : win_l - win_r;
            size_y = (win_t > win_b) ? win_t - win_b : win_b - win_t;
            if (size_x == 0)
                size_x = 1;
            if (size_y == 0)
                size_y = 1;
            if (rot)
            begin
                t = x0; x0 = y0; y0 = t;
                t = x1; x1 = y1; y1 = t;
                x0 = win_r - (x0 - win_l);
                x1 = win_r - (x1 - win_l);
            end
            // Only a single point above the twinkle level flashes.
            if (int'(v.col) <= twinkle || x0 != x1 || y0 != y1)
                r.bri = 7'((int'(v.col) + 1) * 8 - 1);
            else
                r.bri = 7'((127 * (sine_tab[v.ph] + 49152)) / 65536);
            if (mir_x)
            begin
                x0 = win_r - (x0 - win_l);
                x1 = win_r - (x1 - win_l);
            end
            if (mir_y)
            begin
                y0 = win_t - (y0 - win_b);
                y1 = win_t - (y1 - win_b);
            end
            r.vsx = scale_coord(x0, size_x);
            r.vsy = scale_coord(y0, size_y);
            r.vex = scale_coord(x1, size_x);
            r.vey = scale_coord(y1, size_y);
            return r;
        end
    endfunction

    // Driver: records each accepted item and presents the next one.
    always @(posedge clk)
    begin
        vec_item_t nxt;
        bit        drive_next;
        if (rst_n)
        begin
            if (start && !busy)
                expected_views.push_back(transform_vector(on_ports));
            if (!start || !busy)
            begin
                drive_next = 1'b0;
                if (gap_cnt > 0)
                    gap_cnt <= gap_cnt - 1;
                else if (pending_vecs.size() > 0)
                begin
                    if (!no_idle && $urandom_range(0, 5) == 0)
                        gap_cnt <= $urandom_range(0, 6);
                    else
                        drive_next = 1'b1;
                end
                if (drive_next)
                begin
                    nxt = pending_vecs.pop_front();
                    on_ports <= nxt;
                    start_x <= nxt.sx;
                    start_y <= nxt.sy;
                    end_x <= nxt.ex;
                    end_y <= nxt.ey;
                    colour <= nxt.col;
                    frame_phase <= nxt.ph;
                end
                start <= drive_next;
            end
        end
    end

    // Monitor: every strobed result must match the oldest expectation.
    always @(posedge clk)
    begin
        view_item_t want;
        if (rst_n && done)
        begin
            if (expected_views.size() == 0)
            begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("Unexpected result: %0d %0d %0d %0d bri %0d",
                             view_start_x, view_start_y, view_end_x, view_end_y,
                             brightness);
            end
            else
            begin
                want = expected_views.pop_front();
                if (want.vsx !== view_start_x || want.vsy !== view_start_y ||
                    want.vex !== view_end_x || want.vey !== view_end_y ||
                    want.bri !== brightness)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("Mismatch: expected %0d %0d %0d %0d bri %0d, got %0d %0d %0d %0d bri %0d",
                                 want.vsx, want.vsy, want.vex, want.vey, want.bri,
                                 view_start_x, view_start_y, view_end_x, view_end_y,
                                 brightness);
                end
            end
        end
    end

    // Register write; random upper data bits must be ignored by narrow registers.
    task automatic write_reg(reg_idx_t idx, int value);
        logic [11:0] d;
        begin
            d = 12'(value);
            if (idx == REG_ROTATE || idx == REG_MIRROR_X || idx == REG_MIRROR_Y)
                d[11:1] = 11'($urandom);
            else if (idx == REG_TWINKLE)
                d[11:8] = 4'($urandom);
            @(posedge clk);
            cfg_we <= 1'b1;
            cfg_index <= idx;
            cfg_data <= d;
            @(posedge clk);
            cfg_we <= 1'b0;
            case (idx)
                REG_WIN_LEFT:   win_l = int'($signed(d));
                REG_WIN_BOTTOM: win_b = int'($signed(d));
                REG_WIN_RIGHT:  win_r = int'($signed(d));
                REG_WIN_TOP:    win_t = int'($signed(d));
                REG_ROTATE:     rot = d[0];
                REG_MIRROR_X:   mir_x = d[0];
                REG_MIRROR_Y:   mir_y = d[0];
                default:        twinkle = int'(d[7:0]);
            endcase
        end
    endtask

    // Waits until every queued item has gone in and every result has come out.
    task automatic drain;
        begin
            @(posedge clk);
            while (pending_vecs.size() > 0 || start || expected_views.size() > 0)
                @(posedge clk);
            repeat (40) @(posedge clk);
        end
    endtask

    task automatic set_window(int l, int b, int r, int t, bit ro, bit mx, bit my, int tw);
        begin
            write_reg(REG_WIN_LEFT, l);
            write_reg(REG_WIN_BOTTOM, b);
            write_reg(REG_WIN_RIGHT, r);
            write_reg(REG_WIN_TOP, t);
            write_reg(REG_ROTATE, ro);
            write_reg(REG_MIRROR_X, mx);
            write_reg(REG_MIRROR_Y, my);
            write_reg(REG_TWINKLE, tw);
        end
    endtask

    function automatic logic [11:0] rand_coord();
        case ($urandom_range(0, 7))
            0:       return 12'h800;
            1:       return 12'h7FF;
            default: return 12'($urandom);
        endcase
    endfunction

    task automatic queue_vec(int x0, int y0, int x1, int y1, int c, int p);
        vec_item_t v;
        begin
            v.sx = 12'(x0);
            v.sy = 12'(y0);
            v.ex = 12'(x1);
            v.ey = 12'(y1);
            v.col = 4'(c);
            v.ph = 5'(p);
            pending_vecs.push_back(v);
        end
    endtask

    // About a quarter of the random vectors are single points, so they can flash.
    task automatic queue_random(int n);
        vec_item_t v;
        begin
            repeat (n)
            begin
                v.sx = rand_coord();
                v.sy = rand_coord();
                if ($urandom_range(0, 3) == 0)
                begin
                    v.ex = v.sx;
                    v.ey = v.sy;
                end
                else
                begin
                    v.ex = rand_coord();
                    v.ey = rand_coord();
                end
                v.col = 4'($urandom);
                v.ph = 5'($urandom);
                pending_vecs.push_back(v);
            end
        end
    endtask

    function automatic int rand_bound();
        case ($urandom_range(0, 5))
            0:       return -2048;
            1:       return 2047;
            default: return $urandom_range(0, 4095) - 2048;
        endcase
    endfunction

    // Stimulus sequence.
    initial
    begin
        int l, b;
        rst_n = 1'b0;
        start = 1'b0;
        start_x = '0;
        start_y = '0;
        end_x = '0;
        end_y = '0;
        colour = '0;
        frame_phase = '0;
        cfg_we = 1'b0;
        cfg_index = REG_WIN_LEFT;
        cfg_data = '0;
        gap_cnt = 0;
        no_idle = 1'b0;
        mismatches = 0;
        on_ports = '0;
        win_l = 0; win_b = 0; win_r = 0; win_t = 0;
        rot = 0; mir_x = 0; mir_y = 0; twinkle = 255;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: zero-size window, taken as size one, so every nonzero coordinate saturates.
        queue_vec(-2048, -2048, 2047, 2047, 0, 0);
        queue_vec(0, 0, 0, 0, 15, 8);
        queue_vec(1, -1, 0, 0, 7, 3);
        drain();

        // Full window, low twinkle level: flashing points at several phases.
        set_window(-2048, -2048, 2047, 2047, 0, 0, 0, 0);
        queue_vec(-2048, -2048, -2048, -2048, 1, 0);
        queue_vec(2047, 2047, 2047, 2047, 15, 8);
        queue_vec(5, 5, 5, 5, 15, 24);
        queue_vec(5, 5, 5, 5, 0, 24);
        queue_vec(100, -100, 101, -100, 15, 16);
        queue_vec(-2048, 2047, 2047, -2048, 9, 31);
        queue_vec(0, 0, 0, 0, 15, 31);
        drain();

        // Rotation with mirrors on a reversed full window.
        set_window(2047, 2047, -2048, -2048, 1, 1, 1, 14);
        queue_vec(-2048, 2047, -2048, 2047, 15, 4);
        queue_vec(3, 7, 3, 7, 15, 12);
        queue_vec(2047, -2048, 0, 0, 15, 20);
        drain();

        // Tiny window with rotation only, so every nonzero coordinate saturates.
        set_window(0, 0, 1, 1, 1, 0, 0, 255);
        queue_vec(-2048, -2048, 2047, 2047, 15, 1);
        queue_vec(1, 0, 0, 1, 15, 2);
        drain();

        // Random phases; the sender pauses fully at each settings change.
        repeat (14)
        begin
            l = rand_bound();
            b = rand_bound();
            set_window(l, b, ($urandom_range(0, 7) == 0) ? l : rand_bound(),
                       ($urandom_range(0, 7) == 0) ? b : rand_bound(),
                       $urandom_range(0, 1), $urandom_range(0, 1),
                       $urandom_range(0, 1), $urandom_range(0, 15));
            queue_random(110);
            drain();
        end

        // Last stretch runs back to back.
        no_idle = 1'b1;
        set_window(-2048, 2047, 2047, -2048, 0, 1, 0, 7);
        queue_random(150);
        drain();

        if (mismatches == 0 && expected_views.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #(20 * 400000);
        $display("FAIL");
        $finish;
    end

endmodule

### files.f
sv/vwvt_pkg.sv
sv/vwvt_lane.sv
sv/vwvt_front.sv
sv/vector_window_viewport_transform.sv
tb/vector_window_viewport_transform_tb.sv
